/* hdl/dvcs_pkg.sv */
`default_nettype none

package dvcs_pkg;

  // Sequencer phases, in the encoding reported on the output.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CHECK = 2'd1,
    PH_DRAIN = 2'd2,
    PH_COOL  = 2'd3
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_EC_THRESHOLD     = 2'd0,
    REG_SECOND_THRESHOLD = 2'd1,
    REG_CLEANING_TIME    = 2'd2,
    REG_COOLDOWN_TIME    = 2'd3
  } reg_index_t;

  // Command codes carried on the input tuser.
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 88;

  // Second threshold bands.
  localparam logic [15:0] TRIG_OFF_ABOVE = 16'd1400;
  localparam logic [15:0] TRIG_LOW_BELOW = 16'd700;

  // Unsigned 32-bit divide by 60: q = (x * DIV60_MAGIC) >> DIV60_SHIFT, exact over the range.
  localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
  localparam int          DIV60_SHIFT = 37;

  // State after one step, handed from the sequencer to the output pipeline.
  typedef struct packed {
    phase_t      phase;
    logic        valve;
    logic [15:0] drain;
    logic [15:0] cool;
    logic [31:0] total;
    logic        new_minutes;
  } step_res_t;

endpackage

`default_nettype wire

/* hdl/dvcs_core.sv */
`default_nettype none

module dvcs_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dvcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dvcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                step_en,
  input  wire logic                                command,
  input  wire logic                                running,
  input  wire logic [15:0]                         conductivity,
  input  wire logic [31:0]                         time_now,
  output dvcs_pkg::step_res_t                      res
);
  import dvcs_pkg::*;

  logic [15:0] ec_threshold;
  logic [15:0] second_threshold;
  logic [15:0] cleaning_time;
  logic [15:0] cooldown_time;

  phase_t      phase, phase_next;
  logic        valve, valve_next;
  logic [15:0] start_time, start_time_next;  // only the low 16 bits feed elapsed times
  logic [15:0] drain, drain_next;
  logic [15:0] cool, cool_next;
  logic [31:0] total, total_next;
  logic        new_minutes;

  logic        trig;
  logic [15:0] elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      ec_threshold     <= '0;
      second_threshold <= '0;
      cleaning_time    <= '0;
      cooldown_time    <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_EC_THRESHOLD:     ec_threshold     <= cfg_data;
        REG_SECOND_THRESHOLD: second_threshold <= cfg_data;
        REG_CLEANING_TIME:    cleaning_time    <= cfg_data;
        REG_COOLDOWN_TIME:    cooldown_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Second threshold is off above its upper band, compares down below the lower, else up.
  always_comb begin
    trig = (conductivity >= ec_threshold);
    if (second_threshold <= TRIG_OFF_ABOVE) begin
      if (second_threshold < TRIG_LOW_BELOW) begin
        trig = trig | (conductivity <= second_threshold);
      end else begin
        trig = trig | (conductivity >= second_threshold);
      end
    end
  end

  assign elapsed = time_now[15:0] - start_time;

  always_comb begin
    phase_next      = phase;
    valve_next      = valve;
    start_time_next = start_time;
    drain_next      = drain;
    cool_next       = cool;
    total_next      = total;
    new_minutes     = 1'b0;
    if (command == CMD_CLEAR) begin
      total_next = '0;
    end else if (!running) begin
      phase_next = PH_IDLE;
    end else begin
      unique case (phase)
        PH_IDLE, PH_CHECK: begin
          if (phase == PH_IDLE) begin
            phase_next = PH_CHECK;
            drain_next = '0;
            cool_next  = '0;
          end
          if (trig) begin
            valve_next      = 1'b1;
            phase_next      = PH_DRAIN;
            start_time_next = time_now[15:0];
          end
        end
        PH_DRAIN: begin
          drain_next = elapsed;
          if (elapsed >= cleaning_time) begin
            phase_next      = PH_COOL;
            start_time_next = time_now[15:0];
            total_next      = total + {16'd0, elapsed};
            new_minutes     = 1'b1;
            valve_next      = 1'b0;
          end
        end
        PH_COOL: begin
          cool_next = elapsed;
          if (elapsed > cooldown_time) begin
            phase_next = PH_CHECK;
            drain_next = '0;
            cool_next  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      valve      <= 1'b0;
      start_time <= '0;
      drain      <= '0;
      cool       <= '0;
      total      <= '0;
    end else if (step_en) begin
      phase      <= phase_next;
      valve      <= valve_next;
      start_time <= start_time_next;
      drain      <= drain_next;
      cool       <= cool_next;
      total      <= total_next;
    end
  end

  assign res = '{phase: phase_next, valve: valve_next, drain: drain_next, cool: cool_next,
                 total: total_next, new_minutes: new_minutes};

endmodule

`default_nettype wire

/* hdl/dvcs_out.sv */
`default_nettype none

module dvcs_out (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                load,
  input  dvcs_pkg::step_res_t                      res,
  output logic                                     ready,
  output logic                                     stage_valid,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [dvcs_pkg::OUT_TDATA_W-1:0]         out_data
);
  import dvcs_pkg::*;

  step_res_t   stage;
  logic        out_load;
  logic [63:0] product;
  logic [15:0] minutes, minutes_next;

  assign out_load = stage_valid && (!out_valid || out_ready);
  assign ready    = !stage_valid || out_load;

  // The divide by 60 sits between the stage register and the output register.
  assign product      = {32'd0, stage.total} * {32'd0, DIV60_MAGIC};
  assign minutes_next = stage.new_minutes ? product[DIV60_SHIFT +: 16] : minutes;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      minutes     <= '0;
    end else begin
      if (load) begin
        stage_valid <= 1'b1;
      end else if (out_load) begin
        stage_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        minutes   <= minutes_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage <= res;
    end
    if (out_load) begin
      out_data <= {5'd0, stage.total, minutes_next, stage.cool, stage.drain, stage.valve,
                   stage.phase};
    end
  end

endmodule

`default_nettype wire

/* hdl/drain_valve_cleaning_sequencer_unit.sv */
`default_nettype none

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: running, conductivity, time_now;
//                                              tuser: command
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: phase, valve_open, drain_elapsed,
//                                              cooldown_elapsed, total_minutes, total_seconds
// cfg       in   cfg_we (no wait)              cfg_index, cfg_data
//
// One item is accepted per cycle when the output side keeps up. The sequencer state is
// updated at the edge that accepts an item; the result is then held in a stage register,
// where the divide by 60 of the drain total (one 32x32 multiply) runs, and moves on to the
// output register once that is free. Reset is synchronous and returns the sequencer to
// idle with all counts and totals at zero. When the output stalls, the stage register
// still holds one more item before tready drops.

module drain_valve_cleaning_sequencer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dvcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dvcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [0] running, [16:1] conductivity, [48:17] time_now, [55:49] zero
  input  wire logic [dvcs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] command
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [1:0] phase, [2] valve_open, [18:3] drain_elapsed, [34:19] cooldown_elapsed,
  // [50:35] total_minutes, [82:51] total_seconds, [87:83] zero
  output logic [dvcs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
  import dvcs_pkg::*;

  logic      accept;
  logic      stage_valid;
  step_res_t res;

  assign accept = s_axis_tvalid && s_axis_tready;

  dvcs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step_en      (accept),
    .command      (s_axis_tuser),
    .running      (s_axis_tdata[0]),
    .conductivity (s_axis_tdata[16:1]),
    .time_now     (s_axis_tdata[48:17]),
    .res          (res)
  );

  dvcs_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .res         (res),
    .ready       (s_axis_tready),
    .stage_valid (stage_valid),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

  // The valve is always open while draining.
  a_drain_valve: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == PH_DRAIN) |-> m_axis_tdata[2])
    else $error("draining reported with valve closed");

  // The valve is always closed during cooldown.
  a_cool_valve: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == PH_COOL) |-> !m_axis_tdata[2])
    else $error("cooldown reported with valve open");

  // Checking always starts with both elapsed counts cleared.
  a_check_counts: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == PH_CHECK) |-> (m_axis_tdata[34:3] == 32'd0))
    else $error("checking phase with nonzero elapsed counts");

  // An empty stage register never blocks the input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> s_axis_tready)
    else $error("input stalled with empty stage register");

endmodule

`default_nettype wire

/* sim/dvcs_sequencer_checker.sv */
module dvcs_sequencer_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [dvcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dvcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  // [0] running, [16:1] conductivity, [48:17] time_now, [55:49] zero
  input  wire logic [dvcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  wire logic                             s_axis_tuser,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [1:0] phase, [2] valve_open, [18:3] drain_elapsed, [34:19] cooldown_elapsed,
  // [50:35] total_minutes, [82:51] total_seconds, [87:83] zero
  input  wire logic [dvcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                                    mismatches,
  output int                                    results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import dvcs_pkg::*;

  localparam int          REPORT_LIMIT       = 10;
  localparam logic [31:0] SECONDS_PER_MINUTE = 32'd60;

  typedef struct packed {
    phase_t      phase;
    logic        valve;
    logic [15:0] drain;
    logic [15:0] cool;
    logic [15:0] minutes;
    logic [31:0] total;
  } valve_report_t;

  logic [15:0] ec_level;
  logic [15:0] band_level;
  logic [15:0] clean_secs;
  logic [15:0] cool_secs;

  phase_t      seq_phase;
  logic [31:0] seq_start;
  logic [15:0] seq_drain;
  logic [15:0] seq_cool;
  logic [31:0] seq_total;
  logic        seq_valve;
  logic [15:0] seq_minutes;

  valve_report_t reports_due[$];

  function automatic logic cleaning_due(input logic [15:0] cond);
    if (cond >= ec_level) return 1'b1;
    if (band_level > TRIG_OFF_ABOVE) return 1'b0;
    if (band_level < TRIG_LOW_BELOW) return cond <= band_level;
    return cond >= band_level;
  endfunction

  task automatic advance_sequencer(input logic cmd, input logic run,
                                   input logic [15:0] cond, input logic [31:0] now);
    valve_report_t snap;
    if (cmd == CMD_CLEAR) begin
      seq_total = '0;
    end else if (!run) begin
      seq_phase = PH_IDLE;
    end else begin
      case (seq_phase)
        PH_IDLE, PH_CHECK: begin
          if (seq_phase == PH_IDLE) begin
            seq_drain = '0;
            seq_cool  = '0;
          end
          seq_phase = PH_CHECK;
          if (cleaning_due(cond)) begin
            seq_valve = 1'b1;
            seq_phase = PH_DRAIN;
            seq_start = now;
          end
        end
        PH_DRAIN: begin
          seq_drain = 16'(now - seq_start);
          if (seq_drain >= clean_secs) begin
            seq_phase   = PH_COOL;
            seq_start   = now;
            seq_total   = seq_total + 32'(seq_drain);
            seq_minutes = 16'(seq_total / SECONDS_PER_MINUTE);
            seq_valve   = 1'b0;
          end
        end
        default: begin
          seq_cool = 16'(now - seq_start);
          if (seq_cool > cool_secs) begin
            seq_phase = PH_CHECK;
            seq_drain = '0;
            seq_cool  = '0;
          end
        end
      endcase
    end
    snap.phase   = seq_phase;
    snap.valve   = seq_valve;
    snap.drain   = seq_drain;
    snap.cool    = seq_cool;
    snap.minutes = seq_minutes;
    snap.total   = seq_total;
    reports_due.push_back(snap);
  endtask

  always @(posedge clk) begin : watch
    valve_report_t got;
    valve_report_t want;
    if (rst) begin
      ec_level    = '0;
      band_level  = '0;
      clean_secs  = '0;
      cool_secs   = '0;
      seq_phase   = PH_IDLE;
      seq_start   = '0;
      seq_drain   = '0;
      seq_cool    = '0;
      seq_total   = '0;
      seq_valve   = 1'b0;
      seq_minutes = '0;
      reports_due.delete();
      mismatches  = 0;
      results_due = 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_EC_THRESHOLD:     ec_level   = cfg_data;
          REG_SECOND_THRESHOLD: band_level = cfg_data;
          REG_CLEANING_TIME:    clean_secs = cfg_data;
          REG_COOLDOWN_TIME:    cool_secs  = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        advance_sequencer(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[16:1],
                          s_axis_tdata[48:17]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.phase   = phase_t'(m_axis_tdata[1:0]);
        got.valve   = m_axis_tdata[2];
        got.drain   = m_axis_tdata[18:3];
        got.cool    = m_axis_tdata[34:19];
        got.minutes = m_axis_tdata[50:35];
        got.total   = m_axis_tdata[82:51];
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with no item outstanding: tdata=%h", $realtime, m_axis_tdata);
        end else begin
          want = reports_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected phase=%0d valve=%0d drain=%0d cool=%0d min=%0d total=%0d",
                       want.phase, want.valve, want.drain, want.cool, want.minutes, want.total);
              $display("  actual   phase=%0d valve=%0d drain=%0d cool=%0d min=%0d total=%0d",
                       got.phase, got.valve, got.drain, got.cool, got.minutes, got.total);
            end
          end
        end
      end
      results_due = reports_due.size();
    end
  end

endmodule

/* sim/tb_drain_valve_cleaning_sequencer_unit.sv */
module tb_drain_valve_cleaning_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dvcs_pkg::*;

  // The longest intended silence on both channels is the receiver hold-off below; the
  // watchdog allows many times that before it calls the run hung.
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_SETTINGS = 8;
  // Margin waited after the last outstanding result has been taken.
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [15:0] ec;
    logic [15:0] band;
    logic [15:0] clean;
    logic [15:0] cool;
  } sequencer_setup_t;

  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index      = '0;
  logic [CFG_DATA_W-1:0]  cfg_data       = '0;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  // [0] running, [16:1] conductivity, [48:17] time_now, [55:49] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
  // [0] command
  logic                   s_axis_tuser   = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  // [1:0] phase, [2] valve_open, [18:3] drain_elapsed, [34:19] cooldown_elapsed,
  // [50:35] total_minutes, [82:51] total_seconds, [87:83] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int   mismatches;
  int   results_due;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;

  always #5 clk = ~clk;

  drain_valve_cleaning_sequencer_unit dut (.*);

  dvcs_sequencer_checker scoreboard (.*);

  // Output side. Normally tready is drawn at random against the stall percentage of the
  // current phase. When the stimulus raises hold_req, the receiver refuses results for a
  // long fixed stretch, counted here, so that the block backs up and drops s_axis_tready
  // while the sender keeps offering items.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_seen     <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!hold_req) hold_seen <= 1'b0;
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item and returns at the edge that accepts it. Random idle cycles go
  // in front of the item, so gaps land on whatever the sequencer happens to be doing.
  task automatic offer_item(input logic cmd, input logic run,
                            input logic [15:0] cond, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, now, cond, run};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every accepted item has produced its result.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers, one per cycle; only called while the block is idle.
  task automatic load_setup(input sequencer_setup_t setup);
    logic [15:0] vals[4];
    vals[REG_EC_THRESHOLD]     = setup.ec;
    vals[REG_SECOND_THRESHOLD] = setup.band;
    vals[REG_CLEANING_TIME]    = setup.clean;
    vals[REG_COOLDOWN_TIME]    = setup.cool;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_index_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    sequencer_setup_t setups[NUM_SETTINGS];
    int               send_modes[4];
    int               stall_modes[4];
    int               level;
    int               jitter;
    int               pick;
    logic             cmd;
    logic             run;
    logic [15:0]      cond;
    logic [31:0]      clock_s;

    send_modes  = '{0, 59, 0, 36};
    stall_modes = '{0, 0, 59, 36};

    // Both ends of every register, each band of the second threshold (below the low
    // band edge, on it, on the upper edge, just past it), then two random settings.
    setups[0] = '{16'd0, 16'd0, 16'd0, 16'd0};
    setups[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    setups[2] = '{16'd2000, TRIG_LOW_BELOW - 16'd1, 16'd5, 16'd3};
    setups[3] = '{16'd2000, TRIG_LOW_BELOW, 16'd2, 16'd0};
    setups[4] = '{16'd3000, TRIG_OFF_ABOVE, 16'd10, 16'd6};
    setups[5] = '{16'd3000, TRIG_OFF_ABOVE + 16'd1, 16'd1, 16'd1};
    for (int i = 6; i < NUM_SETTINGS; i++)
      setups[i] = '{16'($urandom_range(500, 4000)), 16'($urandom_range(2000)),
                    16'($urandom_range(30)), 16'($urandom_range(30))};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through every phase with no idling on either side. Trigger at 1000
    // or above, or at 500 or below, drain for 3 s, cool for more than 2 s.
    load_setup('{16'd1000, 16'd500, 16'd3, 16'd2});
    clock_s = 32'd100;
    offer_item(CMD_STEP,  1'b0, 16'd0,     clock_s);          // not running from idle
    offer_item(CMD_STEP,  1'b1, 16'd800,   clock_s);          // idle to checking, no trigger
    offer_item(CMD_STEP,  1'b1, 16'd1000,  clock_s + 1);      // trigger exactly at threshold
    offer_item(CMD_STEP,  1'b1, 16'd1000,  clock_s + 2);      // draining, 1 s elapsed
    offer_item(CMD_STEP,  1'b0, 16'd0,     clock_s + 3);      // stop with the valve open
    offer_item(CMD_STEP,  1'b1, 16'hFFFF,  clock_s + 4);      // restart clears counts, triggers
    offer_item(CMD_STEP,  1'b1, 16'd0,     clock_s + 7);      // drain done, total grows
    offer_item(CMD_CLEAR, 1'b1, 16'd0,     clock_s + 8);      // clear keeps the minutes
    offer_item(CMD_STEP,  1'b1, 16'd0,     clock_s + 9);      // cooldown at its limit
    offer_item(CMD_STEP,  1'b1, 16'd800,   clock_s + 10);     // cooldown past its limit
    offer_item(CMD_STEP,  1'b1, 16'd500,   32'hFFFF_FFFE);    // low band trigger at 500
    offer_item(CMD_STEP,  1'b1, 16'd501,   32'd1);            // seconds count wraps
    offer_item(CMD_STEP,  1'b1, 16'd501,   32'd70001);        // elapsed wraps at 16 bits
    offer_item(CMD_STEP,  1'b1, 16'd501,   32'd70002);        // checking, no trigger
    offer_item(CMD_STEP,  1'b1, 16'd0,     32'd5000);         // trigger at zero reading
    offer_item(CMD_STEP,  1'b1, 16'd0,     32'd70538);        // 65538 s reads as 2 s
    offer_item(CMD_STEP,  1'b1, 16'd0,     32'd70539);        // 3 s after wrap: drain done
    offer_item(CMD_CLEAR, 1'b0, 16'hFFFF,  32'hFFFF_FFFF);    // clear while not running
    offer_item(CMD_STEP,  1'b1, 16'd999,   32'hFFFF_FFFF);    // cooldown ends on a jump in time
    offer_item(CMD_STEP,  1'b1, 16'd700,   32'd0);
    wait_drained();

    // Random phases. Readings cluster around both thresholds so the trigger edges are
    // exercised, time mostly creeps forward in small steps so sequences run through
    // draining and cooldown, with occasional wraps and jumps to any value.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      load_setup(setups[p]);
      send_idle_pct  = send_modes[p % 4];
      recv_stall_pct <= stall_modes[p % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 60) hold_req <= 1'b1;
        if (p == 2 && n == 120) hold_req <= 1'b0;

        cmd = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_STEP;
        run = ($urandom_range(99) < 92);

        pick   = $urandom_range(9);
        jitter = $urandom_range(10);
        if (pick < 4) level = int'(setups[p].band) + jitter - 5;
        else if (pick < 7) level = int'(setups[p].ec) + jitter - 5;
        else level = $urandom_range(65535);
        if (level < 0) level = 0;
        if (level > 65535) level = 65535;
        cond = 16'(level);

        pick = $urandom_range(99);
        if (pick < 70) clock_s = clock_s + $urandom_range(4);
        else if (pick < 85) clock_s = clock_s + $urandom_range(40);
        else if (pick < 93) clock_s = clock_s + 32'd65534 + $urandom_range(4);
        else if (pick < 97) clock_s = 32'hFFFF_FFFF - $urandom_range(8);
        else clock_s = $urandom;

        offer_item(cmd, run, cond, clock_s);
      end
      wait_drained();
    end

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/dvcs_pkg.sv
hdl/dvcs_core.sv
hdl/dvcs_out.sv
hdl/drain_valve_cleaning_sequencer_unit.sv
sim/dvcs_sequencer_checker.sv
sim/tb_drain_valve_cleaning_sequencer_unit.sv
